FILE: sv/htb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_pkg
// Shared widths, command kinds and the front-to-back command record.
// ----------------------------------------------------------------------------
package htb_pkg;

	localparam int MAX_SYMBOLS = 256;
	localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
	localparam int SYM_W       = 8;
	localparam int FREQ_W      = 24;
	localparam int CNT_W       = 32;
	localparam int NODE_W      = $clog2(NODE_SLOTS);
	localparam int SLOT_W      = $clog2(MAX_SYMBOLS);
	localparam int LOAD_W      = $clog2(MAX_SYMBOLS + 1);
	localparam int CODE_W      = 8;
	localparam int BIT_W       = $clog2(CODE_W);

	typedef enum logic {
		KIND_ENTRY = 1'b0,
		KIND_CODE  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [SYM_W-1:0]   symbol;
		logic [FREQ_W-1:0]  frequency;
		logic               entry_last;
		logic [CODE_W-1:0]  code_byte;
	} cmd_t;

endpackage

FILE: sv/htb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_if
// Input item channel and decoded result channel.
// ----------------------------------------------------------------------------
interface htb_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] symbol;
	logic [23:0] frequency;
	logic       entry_last;
	logic [7:0] code_byte;

	modport source (output valid, mode, symbol, frequency, entry_last, code_byte,
		input ready);
	modport sink (input valid, mode, symbol, frequency, entry_last, code_byte,
		output ready);
endinterface

interface htb_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] decoded_symbol;
	logic       run_last;
	logic       stream_done;

	modport source (output valid, decoded_symbol, run_last, stream_done, input ready);
	modport sink (input valid, decoded_symbol, run_last, stream_done, output ready);
endinterface

FILE: sv/huffman_table_build_and_decode.sv
`timescale 1ns / 1ps
// Dictionary entry: passes through the two-entry input queue to the back end.
// Tree build: n-1 rounds, each a full scan of the n loaded slots through the
// slot memory port followed by a merge, then a finish step.
// Code byte: accepted in S_IDLE, then S_WALK per code bit, S_EMIT per symbol
// and S_FLUSH for the held symbol; a byte with no tree built or after the
// stream is done is dropped. arst_n clears all control state.
// ----------------------------------------------------------------------------
// huffman_table_build_and_decode
// Huffman tree build from a symbol/count dictionary and code-byte decoder.
// ----------------------------------------------------------------------------
module huffman_table_build_and_decode
	import htb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	htb_item_if.sink      item,
	htb_result_if.source  result
);

	// Command queue between the classifying front and the working back end.
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Front: accept each transaction, tag it as entry or code byte, queue it.
	htb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	// Back: load slots, build the tree, walk code bits and deliver symbols.
	// The last symbol of each byte is held until the byte ends so that its
	// run_last flag is known before it is handed to the output register.
	htb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.result    (result)
	);

endmodule

FILE: sv/htb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_front
// Accept items, classify them as dictionary entry or code byte, and queue
// them in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module htb_front
	import htb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	htb_item_if.sink     item,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  logic         cmd_ready
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       cmd_in;

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = fifo_q[rd_ptr_q];

	always_comb begin
		cmd_in.kind       = item.mode ? KIND_CODE : KIND_ENTRY;
		cmd_in.symbol     = item.symbol;
		cmd_in.frequency  = item.frequency;
		cmd_in.entry_last = item.entry_last;
		cmd_in.code_byte  = item.code_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/htb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_back
// Load the dictionary, build the tree by repeated two-minimum scans over the
// slot memory, then walk the tree one code bit per cycle, pausing to emit.
// ----------------------------------------------------------------------------
module htb_back
	import htb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  cmd_t         cmd,
	output logic         cmd_ready,
	htb_result_if.source result
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_MERGE = 7'b0000100,
		S_FIN   = 7'b0001000,
		S_WALK  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	// memories
	logic [SYM_W-1:0]          leaf_mem  [MAX_SYMBOLS];
	logic [NODE_W+CNT_W-1:0]   slot_mem  [MAX_SYMBOLS];
	logic [2*NODE_W-1:0]       child_mem [2**NODE_W];
	logic [SYM_W-1:0]          sym_rd_q;
	logic [NODE_W+CNT_W-1:0]   slot_rd_q;
	logic [2*NODE_W-1:0]       child_rd_q;

	state_t                state_q;
	logic [LOAD_W-1:0]     loaded_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      emitted_q;
	logic                  done_q;
	logic                  tree_q;
	logic [NODE_W-1:0]     root_q;
	logic [NODE_W-1:0]     cur_q;
	logic [NODE_W-1:0]     next_q;
	logic [LOAD_W-1:0]     idx_q;
	logic [SLOT_W-1:0]     idx_s1;
	logic                  vld_s1;
	logic [CNT_W-1:0]      m1_q, m2_q;
	logic                  m1_v_q, m2_v_q;
	logic [SLOT_W-1:0]     lo1_q, lo2_q;
	logic [NODE_W-1:0]     nd1_q, nd2_q;
	logic [MAX_SYMBOLS-1:0] live_q;
	logic [CODE_W-1:0]     code_q;
	logic [BIT_W-1:0]      bit_q;
	logic [NODE_W-1:0]     nd_q;
	logic                  dn_q;
	logic                  end_q;
	logic                  pend_v_q;
	logic [SYM_W-1:0]      pend_sym_q;
	logic                  pend_dn_q;
	logic                  out_v_q;
	logic [SYM_W-1:0]      out_sym_q;
	logic                  out_last_q;
	logic                  out_dn_q;

	logic                  pop;
	logic                  pop_entry;
	logic [LOAD_W-1:0]     k;
	logic                  can_store;
	logic [LOAD_W-1:0]     new_loaded;
	logic                  single;
	logic [NODE_W-1:0]     child;
	logic [NODE_W-1:0]     nd;
	logic                  is_leaf;
	logic [CNT_W:0]        emit_cnt;
	logic                  emit_dn;
	logic                  out_free;
	logic                  out_load;
	logic [NODE_W-1:0]     cur_d;
	logic [SLOT_W-1:0]     sym_addr;
	logic [NODE_W:0]       last_node;
	logic [CNT_W-1:0]      scan_cnt;
	logic [NODE_W-1:0]     scan_node;

	assign cmd_ready  = (state_q == S_IDLE);
	assign pop        = cmd_valid && cmd_ready;
	assign pop_entry  = pop && (cmd.kind == KIND_ENTRY);
	assign k          = tree_q ? '0 : loaded_q;
	assign can_store  = (k < LOAD_W'(MAX_SYMBOLS));
	assign new_loaded = k + LOAD_W'(can_store);
	assign single     = (loaded_q <= LOAD_W'(1));
	assign child      = code_q[BIT_W'(CODE_W-1) - bit_q] ? child_rd_q[2*NODE_W-1:NODE_W]
	                                                     : child_rd_q[NODE_W-1:0];
	assign nd         = single ? root_q : child;
	assign is_leaf    = single || ({1'b0, nd} < {{(NODE_W+1-LOAD_W){1'b0}}, loaded_q});
	assign emit_cnt   = {1'b0, emitted_q} + (CNT_W+1)'(1);
	assign emit_dn    = (emit_cnt >= {1'b0, total_q});
	assign out_free   = !out_v_q || result.ready;
	assign out_load   = out_free && (((state_q == S_EMIT) && pend_v_q) || (state_q == S_FLUSH));
	assign sym_addr   = (state_q == S_WALK) ? nd[SLOT_W-1:0] : nd_q[SLOT_W-1:0];
	assign last_node  = {NODE_W'(loaded_q), 1'b0} - (NODE_W+1)'(1);
	assign scan_cnt   = slot_rd_q[CNT_W-1:0];
	assign scan_node  = slot_rd_q[NODE_W+CNT_W-1:CNT_W];

	always_comb begin
		cur_d = cur_q;
		case (state_q)
			S_IDLE: begin
				if (pop_entry && tree_q) cur_d = '0;
			end
			S_FIN:   cur_d = next_q - NODE_W'(1);
			S_WALK:  cur_d = is_leaf ? root_q : nd;
			default: cur_d = cur_q;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (pop_entry && can_store) begin
			leaf_mem[k[SLOT_W-1:0]] <= cmd.symbol;
		end
		sym_rd_q <= leaf_mem[sym_addr];
	end

	always_ff @(posedge clk) begin
		if (pop_entry && can_store) begin
			slot_mem[k[SLOT_W-1:0]] <= {NODE_W'(k), CNT_W'(cmd.frequency)};
		end else if (state_q == S_MERGE) begin
			slot_mem[lo1_q] <= {next_q, m1_q + m2_q};
		end
		slot_rd_q <= slot_mem[idx_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MERGE) begin
			child_mem[next_q] <= {nd1_q, nd2_q};
		end
		child_rd_q <= child_mem[cur_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			loaded_q   <= '0;
			total_q    <= '0;
			emitted_q  <= '0;
			done_q     <= 1'b0;
			tree_q     <= 1'b0;
			root_q     <= '0;
			cur_q      <= '0;
			next_q     <= '0;
			idx_q      <= '0;
			idx_s1     <= '0;
			vld_s1     <= 1'b0;
			m1_q       <= '0;
			m2_q       <= '0;
			m1_v_q     <= 1'b0;
			m2_v_q     <= 1'b0;
			lo1_q      <= '0;
			lo2_q      <= '0;
			nd1_q      <= '0;
			nd2_q      <= '0;
			live_q     <= '0;
			code_q     <= '0;
			bit_q      <= '0;
			nd_q       <= '0;
			dn_q       <= 1'b0;
			end_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_sym_q <= '0;
			pend_dn_q  <= 1'b0;
			out_v_q    <= 1'b0;
			out_sym_q  <= '0;
			out_last_q <= 1'b0;
			out_dn_q   <= 1'b0;
		end else begin
			cur_q <= cur_d;
			if (result.ready && !out_load) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop_entry) begin
						// a one-entry dictionary is ready at once
						root_q <= '0;
						tree_q <= cmd.entry_last && (new_loaded == LOAD_W'(1));
						if (tree_q) begin
							emitted_q <= '0;
							done_q    <= 1'b0;
						end
						if (can_store) begin
							live_q <= (tree_q ? '0 : live_q)
							          | (MAX_SYMBOLS'(1) << k[SLOT_W-1:0]);
						end else if (tree_q) begin
							live_q <= '0;
						end
						total_q  <= (tree_q ? '0 : total_q)
						            + (can_store ? CNT_W'(cmd.frequency) : '0);
						loaded_q <= new_loaded;
						if (cmd.entry_last && new_loaded > LOAD_W'(1)) begin
							state_q <= S_SCAN;
							next_q  <= NODE_W'(new_loaded);
							idx_q   <= '0;
							vld_s1  <= 1'b0;
							m1_v_q  <= 1'b0;
							m2_v_q  <= 1'b0;
						end
					end else if (pop) begin
						if (tree_q && !done_q) begin
							code_q  <= cmd.code_byte;
							bit_q   <= '0;
							state_q <= S_WALK;
						end
					end
				end
				S_SCAN: begin
					// issue one slot read per cycle, compare in the cycle after
					if (idx_q != loaded_q) begin
						idx_q  <= idx_q + LOAD_W'(1);
						idx_s1 <= idx_q[SLOT_W-1:0];
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) state_q <= S_MERGE;
					end
					if (vld_s1 && live_q[idx_s1]) begin
						if (!m1_v_q || scan_cnt < m1_q) begin
							m2_q   <= m1_q;
							m2_v_q <= m1_v_q;
							lo2_q  <= lo1_q;
							nd2_q  <= nd1_q;
							m1_q   <= scan_cnt;
							m1_v_q <= 1'b1;
							lo1_q  <= idx_s1;
							nd1_q  <= scan_node;
						end else if (!m2_v_q || scan_cnt < m2_q) begin
							m2_q   <= scan_cnt;
							m2_v_q <= 1'b1;
							lo2_q  <= idx_s1;
							nd2_q  <= scan_node;
						end
					end
				end
				S_MERGE: begin
					live_q[lo2_q] <= 1'b0;
					next_q        <= next_q + NODE_W'(1);
					if ({1'b0, next_q} + (NODE_W+1)'(1) == last_node) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						m1_v_q  <= 1'b0;
						m2_v_q  <= 1'b0;
					end
				end
				S_FIN: begin
					root_q  <= next_q - NODE_W'(1);
					tree_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WALK: begin
					bit_q <= bit_q + BIT_W'(1);
					if (is_leaf) begin
						emitted_q <= emit_cnt[CNT_W-1:0];
						if (emit_dn) done_q <= 1'b1;
						nd_q    <= nd;
						dn_q    <= emit_dn;
						end_q   <= (bit_q == BIT_W'(CODE_W-1)) || emit_dn;
						state_q <= S_EMIT;
					end else if (bit_q == BIT_W'(CODE_W-1)) begin
						state_q <= pend_v_q ? S_FLUSH : S_IDLE;
					end
				end
				S_EMIT: begin
					// hold the newest symbol back until we know if it ends the run
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_sym_q  <= pend_sym_q;
							out_last_q <= 1'b0;
							out_dn_q   <= pend_dn_q;
						end
						pend_v_q   <= 1'b1;
						pend_sym_q <= sym_rd_q;
						pend_dn_q  <= dn_q;
						state_q    <= end_q ? S_FLUSH : S_WALK;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_sym_q  <= pend_sym_q;
						out_last_q <= 1'b1;
						out_dn_q   <= pend_dn_q;
						pend_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid          = out_v_q;
	assign result.decoded_symbol = out_sym_q;
	assign result.run_last       = out_last_q;
	assign result.stream_done    = out_dn_q;

endmodule
